@@ hw/rtl/clt_pkg.sv @@
`timescale 1ns / 1ps

package clt_pkg;

  // Token counter width; the count shown on the result saturates at 255.
  localparam int unsigned COUNT_BITS = 8;
  localparam int unsigned CntExtW    = COUNT_BITS + 8;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChN         = 8'h6E;
  localparam logic [7:0] ChR         = 8'h72;
  localparam logic [7:0] ChT         = 8'h74;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChXLower    = 8'h78;
  localparam logic [7:0] ChXUpper    = 8'h58;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChNul       = 8'h00;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX_HI = 3'd2,
    MODE_HEX_LO = 3'd3,
    MODE_FAILED = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_e;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_LINE_DONE = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_e;

  typedef struct packed {
    mode_e                 mode;
    quote_e                quote;
    logic                  tok_open;
    logic [3:0]            hex_high;
    logic [COUNT_BITS-1:0] tokens;
  } parse_state_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic [7:0] count;
  } result_t;

  localparam parse_state_t StateReset = '{
    mode:     MODE_NORMAL,
    quote:    QUOTE_NONE,
    tok_open: 1'b0,
    hex_high: 4'h0,
    tokens:   '0
  };

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 give its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Count as shown on the result port, clipped at 255.
  function automatic logic [7:0] shown_count(input logic [COUNT_BITS-1:0] t);
    logic [CntExtW-1:0] ext;
    ext = CntExtW'(t);
    return (ext > CntExtW'(255)) ? 8'hFF : ext[7:0];
  endfunction

endpackage

@@ hw/rtl/clt_step.sv @@
`timescale 1ns / 1ps

// Next parse state and optional result for one item.
module clt_step (
  input  logic [7:0]            char_in_i,
  input  logic                  line_end_i,
  input  clt_pkg::parse_state_t state_i,
  output clt_pkg::parse_state_t state_o,
  output logic                  res_valid_o,
  output clt_pkg::result_t      res_o
);

  logic [clt_pkg::COUNT_BITS-1:0] tok_inc;
  logic [4:0]                     hex;
  clt_pkg::quote_e                q_char;
  logic                           is_quote;

  assign tok_inc  = (state_i.tokens == '1) ? state_i.tokens
                                           : state_i.tokens + 1'b1;
  assign hex      = clt_pkg::hex_digit(char_in_i);
  assign is_quote = (char_in_i == clt_pkg::ChSquote) || (char_in_i == clt_pkg::ChDquote);
  assign q_char   = (char_in_i == clt_pkg::ChSquote) ? clt_pkg::QUOTE_SINGLE
                                                     : clt_pkg::QUOTE_DOUBLE;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '{kind: clt_pkg::KIND_BYTE, value: 8'h00,
                    count: clt_pkg::shown_count(state_i.tokens)};

    if (line_end_i) begin
      // end of line: report and clear everything
      state_o     = clt_pkg::StateReset;
      res_valid_o = 1'b1;
      if (state_i.mode != clt_pkg::MODE_NORMAL) begin
        res_o.kind  = clt_pkg::KIND_ERROR;
        res_o.count = 8'h00;
      end else begin
        res_o.kind  = clt_pkg::KIND_LINE_DONE;
        res_o.count = clt_pkg::shown_count(state_i.tok_open ? tok_inc : state_i.tokens);
      end
    end else begin
      unique case (state_i.mode)
        clt_pkg::MODE_FAILED: begin
          // rest of a failed line is dropped
        end
        clt_pkg::MODE_ESCAPE: begin
          state_o.mode = clt_pkg::MODE_NORMAL;
          res_valid_o  = 1'b1;
          state_o.tok_open = 1'b1;
          unique case (char_in_i)
            clt_pkg::ChN:    res_o.value = clt_pkg::ChLf;
            clt_pkg::ChR:    res_o.value = clt_pkg::ChCr;
            clt_pkg::ChT:    res_o.value = clt_pkg::ChTab;
            clt_pkg::ChZero: res_o.value = clt_pkg::ChNul;
            clt_pkg::ChSquote, clt_pkg::ChDquote, clt_pkg::ChSpace: begin
              res_o.value = char_in_i;
            end
            clt_pkg::ChXLower, clt_pkg::ChXUpper: begin
              state_o.mode     = clt_pkg::MODE_HEX_HI;
              state_o.tok_open = state_i.tok_open;
              res_valid_o      = 1'b0;
            end
            default: begin
              state_o.mode     = clt_pkg::MODE_FAILED;
              state_o.tok_open = state_i.tok_open;
              state_o.hex_high = 4'h0;
              res_o.kind       = clt_pkg::KIND_ERROR;
              res_o.count      = 8'h00;
            end
          endcase
        end
        clt_pkg::MODE_HEX_HI: begin
          if (hex[4]) begin
            state_o.hex_high = hex[3:0];
            state_o.mode     = clt_pkg::MODE_HEX_LO;
          end else begin
            state_o.mode     = clt_pkg::MODE_FAILED;
            state_o.hex_high = 4'h0;
            res_valid_o      = 1'b1;
            res_o.kind       = clt_pkg::KIND_ERROR;
            res_o.count      = 8'h00;
          end
        end
        clt_pkg::MODE_HEX_LO: begin
          res_valid_o      = 1'b1;
          state_o.hex_high = 4'h0;
          if (hex[4]) begin
            state_o.mode     = clt_pkg::MODE_NORMAL;
            state_o.tok_open = 1'b1;
            res_o.value      = {state_i.hex_high, hex[3:0]};
          end else begin
            state_o.mode = clt_pkg::MODE_FAILED;
            res_o.kind   = clt_pkg::KIND_ERROR;
            res_o.count  = 8'h00;
          end
        end
        clt_pkg::MODE_NORMAL: begin
          if (char_in_i == clt_pkg::ChBackslash) begin
            state_o.mode = clt_pkg::MODE_ESCAPE;
          end else if (is_quote) begin
            // open, close, or literal other quote
            if (state_i.quote == clt_pkg::QUOTE_NONE) begin
              state_o.quote = q_char;
            end else if (state_i.quote != q_char) begin
              res_valid_o      = 1'b1;
              res_o.value      = char_in_i;
              state_o.tok_open = 1'b1;
            end else begin
              state_o.quote = clt_pkg::QUOTE_NONE;
            end
          end else if (state_i.quote == clt_pkg::QUOTE_NONE &&
                       clt_pkg::is_blank(char_in_i)) begin
            if (state_i.tok_open) begin
              state_o.tok_open = 1'b0;
              state_o.tokens   = tok_inc;
              res_valid_o      = 1'b1;
              res_o.kind       = clt_pkg::KIND_TOKEN_END;
              res_o.count      = clt_pkg::shown_count(tok_inc);
            end
          end else begin
            res_valid_o      = 1'b1;
            res_o.value      = char_in_i;
            state_o.tok_open = 1'b1;
          end
        end
        default: begin
          state_o.mode = clt_pkg::MODE_FAILED;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/clt_out_buf.sv @@
`timescale 1ns / 1ps

// Result register with a skid entry; ready depends only on local state.
module clt_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  clt_pkg::result_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output clt_pkg::result_t data_o
);

  logic             main_valid_q, main_valid_d;
  logic             skid_valid_q, skid_valid_d;
  clt_pkg::result_t main_q, main_d;
  clt_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop     = main_valid_q & ready_i;
  assign ready_o = ~skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  // next-state for main and skid entries
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_valid_q || pop) begin
        main_d       = data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      main_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

@@ hw/rtl/command_line_tokenizer.sv @@
`timescale 1ns / 1ps
// Each result is registered into the output buffer (main or skid entry) as its item is accepted.
// Throughput: one item per cycle while in_ready_o is high; the parse state register closes the loop.
// A two-entry output buffer (main plus skid) keeps items flowing while the consumer stalls, until both fill.
// Reset (rst_ni low, asynchronous): parser back to normal mode, no quote, count 0,
// output buffer empty.
module command_line_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       line_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] value_o,
  output logic [7:0] token_count_o
);

  clt_pkg::parse_state_t state_q, state_d;
  logic                  res_valid;
  clt_pkg::result_t      res;
  clt_pkg::result_t      out_data;
  logic                  accept;

  assign accept = in_valid_i & in_ready_o;

  clt_step u_step (
    .char_in_i  (char_in_i),
    .line_end_i (line_end_i),
    .state_i    (state_q),
    .state_o    (state_d),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // parse state advances on every accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clt_pkg::StateReset;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  clt_out_buf u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept & res_valid),
    .data_i (res),
    .ready_o(in_ready_o),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (out_data)
  );

  assign kind_o        = out_data.kind;
  assign value_o       = out_data.value;
  assign token_count_o = out_data.count;

endmodule

@@ hw/rtl/clt_checker.sv @@
`timescale 1ns / 1ps

module clt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       line_end_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [7:0] value_o,
  input logic [7:0] token_count_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // only token bytes carry a value
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != clt_pkg::KIND_BYTE |-> value_o == 8'h00)
    else $error("nonzero value on non-byte result");

  // errors report a zero count
  a_err_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == clt_pkg::KIND_ERROR |-> token_count_o == 8'h00)
    else $error("error result with nonzero count");

  // a token end always follows at least one completed token
  a_end_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == clt_pkg::KIND_TOKEN_END |-> token_count_o != 8'h00)
    else $error("token end with zero count");

  // a line end, which always yields a result, is visible on the next cycle when output was idle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && line_end_i && !out_valid_o |=> out_valid_o)
    else $error("line end produced no result");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (.*);

@@ tb/command_line_tokenizer_tb.sv @@
`timescale 1ns / 1ps

module command_line_tokenizer_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemTarget = 1350;
  localparam int unsigned HoldCycles = 200;

  // Scoreboard: tracks the parser state and the results it still owes
  class tokenizer_scoreboard;
    clt_pkg::mode_e                 mode;
    clt_pkg::quote_e                quote;
    logic                           in_tok;
    logic [3:0]                     hex_hi;
    logic [clt_pkg::COUNT_BITS-1:0] ntok;
    clt_pkg::result_t               expected_results[$];
    int unsigned                    errors;

    function new();
      clear_line();
      errors = 0;
    endfunction

    function void clear_line();
      mode   = clt_pkg::MODE_NORMAL;
      quote  = clt_pkg::QUOTE_NONE;
      in_tok = 1'b0;
      hex_hi = 4'h0;
      ntok   = '0;
    endfunction

    // Bit 4 set when c is a hex digit, low nibble holds its value
    static function logic [4:0] nibble(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
      if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
      if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
      return 5'h00;
    endfunction

    function logic [7:0] count_shown();
      int unsigned n;
      n = ntok;
      return (n > 255) ? 8'hFF : 8'(n);
    endfunction

    function void push(clt_pkg::kind_e k, logic [7:0] v, logic [7:0] n);
      clt_pkg::result_t r;
      r.kind  = k;
      r.value = v;
      r.count = n;
      expected_results.push_back(r);
    endfunction

    function void push_byte(logic [7:0] b);
      in_tok = 1'b1;
      push(clt_pkg::KIND_BYTE, b, count_shown());
    endfunction

    function void fail_line();
      mode   = clt_pkg::MODE_FAILED;
      hex_hi = 4'h0;
      push(clt_pkg::KIND_ERROR, 8'h00, 8'h00);
    endfunction

    function void bump_count();
      if (ntok != {clt_pkg::COUNT_BITS{1'b1}}) ntok++;
    endfunction

    // Advance the parser by one accepted item and queue what it produces
    function void predict_item(logic [7:0] c, logic e);
      logic [4:0]      h;
      clt_pkg::quote_e q;
      if (e) begin
        if (mode != clt_pkg::MODE_NORMAL) begin
          push(clt_pkg::KIND_ERROR, 8'h00, 8'h00);
        end else begin
          if (in_tok) bump_count();
          push(clt_pkg::KIND_LINE_DONE, 8'h00, count_shown());
        end
        clear_line();
        return;
      end
      case (mode)
        clt_pkg::MODE_FAILED: return;
        clt_pkg::MODE_ESCAPE: begin
          mode = clt_pkg::MODE_NORMAL;
          case (c)
            clt_pkg::ChN:       push_byte(clt_pkg::ChLf);
            clt_pkg::ChR:       push_byte(clt_pkg::ChCr);
            clt_pkg::ChT:       push_byte(clt_pkg::ChTab);
            clt_pkg::ChZero:    push_byte(clt_pkg::ChNul);
            clt_pkg::ChSquote, clt_pkg::ChDquote, clt_pkg::ChSpace: push_byte(c);
            clt_pkg::ChXLower, clt_pkg::ChXUpper: mode = clt_pkg::MODE_HEX_HI;
            default:            fail_line();
          endcase
          return;
        end
        clt_pkg::MODE_HEX_HI: begin
          h = nibble(c);
          if (!h[4]) begin
            fail_line();
          end else begin
            hex_hi = h[3:0];
            mode   = clt_pkg::MODE_HEX_LO;
          end
          return;
        end
        clt_pkg::MODE_HEX_LO: begin
          h = nibble(c);
          if (!h[4]) begin
            fail_line();
          end else begin
            mode = clt_pkg::MODE_NORMAL;
            push_byte({hex_hi, h[3:0]});
            hex_hi = 4'h0;
          end
          return;
        end
        clt_pkg::MODE_NORMAL: ;
        default: begin
          mode = clt_pkg::MODE_FAILED;
          return;
        end
      endcase

      // Normal mode: escapes, quotes, blanks, plain bytes
      if (c == clt_pkg::ChBackslash) begin
        mode = clt_pkg::MODE_ESCAPE;
        return;
      end
      if (c == clt_pkg::ChSquote || c == clt_pkg::ChDquote) begin
        q = (c == clt_pkg::ChSquote) ? clt_pkg::QUOTE_SINGLE : clt_pkg::QUOTE_DOUBLE;
        if (quote == clt_pkg::QUOTE_NONE) quote = q;
        else if (quote != q) push_byte(c);
        else quote = clt_pkg::QUOTE_NONE;
        return;
      end
      if (quote != clt_pkg::QUOTE_NONE) begin
        push_byte(c);
        return;
      end
      if (c == clt_pkg::ChSpace || (c >= 8'h09 && c <= 8'h0D)) begin
        if (in_tok) begin
          in_tok = 1'b0;
          bump_count();
          push(clt_pkg::KIND_TOKEN_END, 8'h00, count_shown());
        end
        return;
      end
      push_byte(c);
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_result(logic [1:0] k, logic [7:0] v, logic [7:0] n);
      clt_pkg::result_t r;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d value %02h count %0d", k, v, n));
        return;
      end
      r = expected_results.pop_front();
      if (k !== r.kind) report($sformatf("kind %0d, expected %0d", k, r.kind));
      if (v !== r.value) report($sformatf("value %02h, expected %02h", v, r.value));
      if (n !== r.count) report($sformatf("token_count %0d, expected %0d", n, r.count));
    endtask

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] char_in_i   = 8'h00;
  logic       line_end_i  = 1'b0;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] value_o;
  logic [7:0] token_count_o;

  tokenizer_scoreboard sb = new();

  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  int unsigned cycle_count = 0;
  bit          hold_req    = 1'b0;

  command_line_tokenizer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_in_i    (char_in_i),
    .line_end_i   (line_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .value_o      (value_o),
    .token_count_o(token_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Offer one item, with a random gap first when a burst runs out
  task automatic send_item(input logic [7:0] c, input logic e);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        char_in_i  <= 8'($urandom);
        line_end_i <= 1'($urandom);
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    char_in_i  <= c;
    line_end_i <= e;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.predict_item(c, e);
    items_sent++;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h21, 8'h7E));
    while (b == clt_pkg::ChSquote || b == clt_pkg::ChDquote || b == clt_pkg::ChBackslash);
    return b;
  endfunction

  function automatic logic [7:0] blank_char();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? clt_pkg::ChSpace : 8'(8'h09 + k);
  endfunction

  function automatic logic [7:0] hex_char();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  task automatic send_good_escape();
    int unsigned k;
    k = $urandom_range(0, 9);
    send_item(clt_pkg::ChBackslash, 1'b0);
    case (k)
      0: send_item(clt_pkg::ChN, 1'b0);
      1: send_item(clt_pkg::ChR, 1'b0);
      2: send_item(clt_pkg::ChT, 1'b0);
      3: send_item(clt_pkg::ChZero, 1'b0);
      4: send_item(clt_pkg::ChSquote, 1'b0);
      5: send_item(clt_pkg::ChDquote, 1'b0);
      6: send_item(clt_pkg::ChSpace, 1'b0);
      default: begin
        send_item(k[0] ? clt_pkg::ChXUpper : clt_pkg::ChXLower, 1'b0);
        send_item(hex_char(), 1'b0);
        send_item(hex_char(), 1'b0);
      end
    endcase
  endtask

  task automatic send_bad_escape();
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == clt_pkg::ChN || b == clt_pkg::ChR || b == clt_pkg::ChT ||
           b == clt_pkg::ChZero || b == clt_pkg::ChSquote || b == clt_pkg::ChDquote ||
           b == clt_pkg::ChSpace || b == clt_pkg::ChXLower || b == clt_pkg::ChXUpper);
    send_item(clt_pkg::ChBackslash, 1'b0);
    send_item(b, 1'b0);
  endtask

  task automatic send_bad_hex();
    logic [7:0] b;
    do b = 8'($urandom);
    while (tokenizer_scoreboard::nibble(b) != 5'h00);
    send_item(clt_pkg::ChBackslash, 1'b0);
    send_item($urandom_range(0, 1) ? clt_pkg::ChXUpper : clt_pkg::ChXLower, 1'b0);
    if ($urandom_range(0, 1)) send_item(hex_char(), 1'b0);
    send_item(b, 1'b0);
  endtask

  // Mostly well-formed lines with random content; some pure noise
  task automatic send_random_line();
    int unsigned len;
    int unsigned pick;
    bit          noise;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
    noise = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (noise || pick >= 83) send_item(8'($urandom), 1'b0);
      else if (pick < 35) send_item(plain_char(), 1'b0);
      else if (pick < 50) send_item(blank_char(), 1'b0);
      else if (pick < 60) send_item(pick[0] ? clt_pkg::ChSquote : clt_pkg::ChDquote, 1'b0);
      else if (pick < 78) send_good_escape();
      else if (pick < 81) send_bad_escape();
      else send_bad_hex();
    end
    // Occasionally end the line with an escape still open
    case ($urandom_range(0, 19))
      0: send_item(clt_pkg::ChBackslash, 1'b0);
      1: begin
        send_item(clt_pkg::ChBackslash, 1'b0);
        send_item(clt_pkg::ChXLower, 1'b0);
      end
      2: begin
        send_item(clt_pkg::ChBackslash, 1'b0);
        send_item(clt_pkg::ChXUpper, 1'b0);
        send_item(hex_char(), 1'b0);
      end
      default: ;
    endcase
    send_item(8'($urandom), 1'b1);
  endtask

  // Receiver: rotating stall pattern plus long hold-offs on request
  initial begin
    int unsigned stall_cycle;
    int unsigned hold_left;
    logic        rdy;
    stall_cycle = 0;
    hold_left   = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_result(kind_o, value_o, token_count_o);
      stall_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
        rdy       = 1'b0;
      end else begin
        case ((stall_cycle / 128) % 4)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ((stall_cycle % 3) != 0);
        endcase
      end
      out_ready_i <= rdy;
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Byte extremes, blank ending a token, empty quoted span
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h0B, 1'b0);
    send_item(clt_pkg::ChDquote, 1'b0);
    send_item(clt_pkg::ChDquote, 1'b0);
    send_item(8'hFF, 1'b1);
    // Escapes inside and outside quotes, other quote literal, unclosed quote
    send_item(clt_pkg::ChBackslash, 1'b0);
    send_item(clt_pkg::ChN, 1'b0);
    send_item(clt_pkg::ChSquote, 1'b0);
    send_item(clt_pkg::ChDquote, 1'b0);
    send_item(clt_pkg::ChBackslash, 1'b0);
    send_item(clt_pkg::ChSpace, 1'b0);
    send_item(clt_pkg::ChBackslash, 1'b0);
    send_item(clt_pkg::ChT, 1'b1);
    // Hex escapes, bad hex digit, bytes ignored after failure
    send_item(clt_pkg::ChBackslash, 1'b0);
    send_item(clt_pkg::ChXLower, 1'b0);
    send_item(8'h34, 1'b0);
    send_item(8'h66, 1'b0);
    send_item(clt_pkg::ChBackslash, 1'b0);
    send_item(clt_pkg::ChXUpper, 1'b0);
    send_item(8'h41, 1'b0);
    send_item(8'h67, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h00, 1'b1);
    // Backslash after backslash, then line end with an escape due
    send_item(clt_pkg::ChBackslash, 1'b0);
    send_item(clt_pkg::ChBackslash, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(clt_pkg::ChBackslash, 1'b0);
    send_item(8'h00, 1'b1);

    // Long line that saturates the token count; receiver holds off meanwhile
    hold_req = 1'b1;
    for (int i = 0; i < 270; i++) begin
      if ($urandom_range(0, 7) == 0) send_good_escape();
      else send_item(plain_char(), 1'b0);
      send_item(blank_char(), 1'b0);
    end
    send_item(8'($urandom), 1'b1);

    while (items_sent < ItemTarget) begin
      if (items_sent > 1000 && items_sent < 1010) hold_req = 1'b1;
      send_random_line();
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
